// File: src/call_trace_symbol_stack_top_macros.svh
// Assertion macros used by the checker.
`ifndef CALL_TRACE_SYMBOL_STACK_TOP_MACROS_SVH
`define CALL_TRACE_SYMBOL_STACK_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctss assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define CTSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctss assertion failed: next-cycle implication");

`endif

// File: src/ctss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctss_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int STACK_DEPTH = 1024;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 10;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 10;
    localparam int DEPTH_W  = 11;
    localparam int CFG_W    = 11;

    localparam int TABLE_AW = $clog2(TABLE_DEPTH);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int SCAN_W   = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_W  = $clog2(STACK_DEPTH + 1);

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [CFG_W-1:0]    cfg_t;
    typedef logic [TABLE_AW-1:0] tbl_addr_t;
    typedef logic [STACK_AW-1:0] stk_addr_t;
    typedef logic [SCAN_W-1:0]   scan_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam op_t OP_LOAD = 2'd0;
    localparam op_t OP_CALL = 2'd1;
    localparam op_t OP_RET  = 2'd2;

    localparam status_t STS_LOADED = 3'd0;
    localparam status_t STS_PUSHED = 3'd1;
    localparam status_t STS_FULL   = 3'd2;
    localparam status_t STS_POPPED = 3'd3;
    localparam status_t STS_EMPTY  = 3'd4;

    typedef struct packed {
        logic   known;
        index_t index;
    } frame_t;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_step;
        logic pop_read;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: src/ctss_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ctss_in_if;
    logic             valid;
    logic             ready;
    ctss_pkg::op_t    op;
    ctss_pkg::slot_t  entry_slot;
    ctss_pkg::addr_t  entry_start;
    ctss_pkg::addr_t  call_target;
    ctss_pkg::addr_t  trace_pc;

    modport source (output valid, output op, output entry_slot, output entry_start,
                    output call_target, output trace_pc, input ready);
    modport sink   (input valid, input op, input entry_slot, input entry_start,
                    input call_target, input trace_pc, output ready);
endinterface

`default_nettype wire

// File: src/ctss_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ctss_out_if;
    logic               valid;
    logic               ready;
    ctss_pkg::status_t  status;
    logic               func_known;
    ctss_pkg::index_t   func_index;
    ctss_pkg::depth_t   nest_depth;
    ctss_pkg::addr_t    pc_echo;
    ctss_pkg::addr_t    target_echo;

    modport source (output valid, output status, output func_known, output func_index,
                    output nest_depth, output pc_echo, output target_echo, input ready);
    modport sink   (input valid, input status, input func_known, input func_index,
                    input nest_depth, input pc_echo, input target_echo, output ready);
endinterface

`default_nettype wire

// File: src/call_trace_symbol_stack_top.sv
// Channel   Dir  Handshake      Payload
// item      in   valid/ready    op, entry_slot, entry_start, call_target, trace_pc
// result    out  valid/ready    status, func_known, func_index, nest_depth, pc_echo, target_echo
// cfg       in   cfg_wr_en      cfg_wr_data (function_count)
//
// One item at a time. Load goes straight to the final step; return reads the top stack frame first;
// an unused op is dropped. Call scans up to min(function_count, 1024) entries; the linear scan of the start table
// reads one entry per cycle through its single registered read port.
// Reset (rst_n low, asynchronous) clears the stack depth, function_count and control.
// A new item is taken while the previous result waits; a stalled result
// holds the block in its final step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module call_trace_symbol_stack_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ctss_in_if.sink              item,
    ctss_out_if.source           result,
    input  wire logic            cfg_wr_en,
    input  wire ctss_pkg::cfg_t  cfg_wr_data
);

    ctss_pkg::cmd_t cmd;
    ctss_pkg::sts_t sts;
    logic           in_ready;

    assign item.ready = in_ready;

    ctss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_op    (item.op),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ctss_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (item.op),
        .entry_slot  (item.entry_slot),
        .entry_start (item.entry_start),
        .call_target (item.call_target),
        .trace_pc    (item.trace_pc),
        .cmd         (cmd),
        .sts         (sts),
        .result      (result)
    );

endmodule

`default_nettype wire

// File: src/ctss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ctss_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire ctss_pkg::op_t  in_op,
    output logic                in_ready,
    output ctss_pkg::cmd_t      cmd,
    input  wire ctss_pkg::sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        ctss_pkg::OP_LOAD:
                        begin
                            cmd.accept = 1'b1;
                            state_next = ST_DONE;
                        end
                        ctss_pkg::OP_CALL:
                        begin
                            cmd.accept     = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        ctss_pkg::OP_RET:
                        begin
                            cmd.accept = 1'b1;
                            state_next = ST_POP;
                        end
                        default:
                        begin
                            // drop the unused op
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                cmd.pop_read = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/ctss_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ctss_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire ctss_pkg::cfg_t   cfg_wr_data,
    input  wire ctss_pkg::op_t    op,
    input  wire ctss_pkg::slot_t  entry_slot,
    input  wire ctss_pkg::addr_t  entry_start,
    input  wire ctss_pkg::addr_t  call_target,
    input  wire ctss_pkg::addr_t  trace_pc,
    input  wire ctss_pkg::cmd_t   cmd,
    output ctss_pkg::sts_t        sts,
    ctss_out_if.source            result
);

    ctss_pkg::addr_t   start_mem [ctss_pkg::TABLE_DEPTH];
    ctss_pkg::frame_t  frame_mem [ctss_pkg::STACK_DEPTH];

    ctss_pkg::cfg_t    func_count_reg;
    ctss_pkg::count_t  count_reg;
    ctss_pkg::count_t  count_next;

    ctss_pkg::op_t     op_reg;
    ctss_pkg::addr_t   target_reg;
    ctss_pkg::addr_t   pc_reg;

    ctss_pkg::scan_t     idx_reg;
    ctss_pkg::scan_t     idx_next;
    logic                chk_vld_reg;
    logic                chk_vld_next;
    ctss_pkg::tbl_addr_t chk_idx_reg;
    ctss_pkg::addr_t     rd_data_reg;
    ctss_pkg::frame_t    frame_reg;
    ctss_pkg::frame_t    pop_data_reg;

    logic                out_vld_reg;
    logic                out_vld_next;
    ctss_pkg::status_t   out_status_reg;
    logic                out_known_reg;
    ctss_pkg::index_t    out_index_reg;
    ctss_pkg::depth_t    out_depth_reg;
    ctss_pkg::addr_t     out_pc_reg;
    ctss_pkg::addr_t     out_target_reg;

    ctss_pkg::scan_t   lim;
    logic              scan_rd;
    logic              hit;
    ctss_pkg::frame_t  scan_frame;
    logic              load_wr;
    logic              stack_full;
    logic              stack_empty;
    logic              push_en;
    logic              pop_en;
    ctss_pkg::status_t res_status;
    logic              res_known;
    ctss_pkg::index_t  res_index;
    ctss_pkg::depth_t  res_depth;
    ctss_pkg::addr_t   res_target;

    assign lim = (int'(func_count_reg) > ctss_pkg::TABLE_DEPTH)
               ? ctss_pkg::scan_t'(ctss_pkg::TABLE_DEPTH)
               : ctss_pkg::scan_t'(func_count_reg);

    assign load_wr = cmd.accept && (op == ctss_pkg::OP_LOAD)
                  && (int'(entry_slot) < ctss_pkg::TABLE_DEPTH);

    assign scan_rd = cmd.scan_step && (idx_reg < lim);
    assign hit     = chk_vld_reg && (rd_data_reg > target_reg);

    always_comb
    begin
        scan_frame = '0;
        if (hit)
        begin
            if (chk_idx_reg != '0)
            begin
                scan_frame.known = 1'b1;
                scan_frame.index = ctss_pkg::index_t'(chk_idx_reg - 1'b1);
            end
        end
        else if (lim != '0)
        begin
            scan_frame.known = 1'b1;
            scan_frame.index = ctss_pkg::index_t'(lim - 1'b1);
        end
    end

    assign sts.scan_done = hit || (!chk_vld_reg && (idx_reg >= lim));
    assign sts.out_free  = !out_vld_reg || result.ready;

    always_comb
    begin
        idx_next     = idx_reg;
        chk_vld_next = chk_vld_reg;
        if (cmd.scan_start)
        begin
            idx_next     = '0;
            chk_vld_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            chk_vld_next = scan_rd;
            if (scan_rd)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    assign stack_full  = (int'(count_reg) >= ctss_pkg::STACK_DEPTH);
    assign stack_empty = (count_reg == '0);

    always_comb
    begin
        res_status = ctss_pkg::STS_LOADED;
        res_known  = 1'b0;
        res_index  = '0;
        res_depth  = ctss_pkg::depth_t'(count_reg);
        res_target = '0;
        push_en    = 1'b0;
        pop_en     = 1'b0;
        case (op_reg)
            ctss_pkg::OP_CALL:
            begin
                res_known  = frame_reg.known;
                res_index  = frame_reg.index;
                res_target = target_reg;
                if (stack_full)
                begin
                    res_status = ctss_pkg::STS_FULL;
                end
                else
                begin
                    res_status = ctss_pkg::STS_PUSHED;
                    push_en    = 1'b1;
                end
            end
            ctss_pkg::OP_RET:
            begin
                if (stack_empty)
                begin
                    res_status = ctss_pkg::STS_EMPTY;
                end
                else
                begin
                    res_status = ctss_pkg::STS_POPPED;
                    res_known  = pop_data_reg.known;
                    res_index  = pop_data_reg.index;
                    res_depth  = ctss_pkg::depth_t'(count_reg - 1'b1);
                    pop_en     = 1'b1;
                end
            end
            default:
            begin
                res_status = ctss_pkg::STS_LOADED;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish && push_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.finish && pop_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.finish)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_count_reg <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                func_count_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= op;
            target_reg <= call_target;
            pc_reg     <= trace_pc;
        end
        if (scan_rd)
        begin
            chk_idx_reg <= ctss_pkg::tbl_addr_t'(idx_reg);
        end
        if (cmd.scan_step && sts.scan_done)
        begin
            frame_reg <= scan_frame;
        end
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_known_reg  <= res_known;
            out_index_reg  <= res_index;
            out_depth_reg  <= res_depth;
            out_pc_reg     <= pc_reg;
            out_target_reg <= res_target;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            start_mem[ctss_pkg::tbl_addr_t'(entry_slot)] <= entry_start;
        end
        if (scan_rd)
        begin
            rd_data_reg <= start_mem[ctss_pkg::tbl_addr_t'(idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && push_en)
        begin
            frame_mem[ctss_pkg::stk_addr_t'(count_reg)] <= frame_reg;
        end
        if (cmd.pop_read && !stack_empty)
        begin
            pop_data_reg <= frame_mem[ctss_pkg::stk_addr_t'(count_reg - 1'b1)];
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.status      = out_status_reg;
    assign result.func_known  = out_known_reg;
    assign result.func_index  = out_index_reg;
    assign result.nest_depth  = out_depth_reg;
    assign result.pc_echo     = out_pc_reg;
    assign result.target_echo = out_target_reg;

endmodule

`default_nettype wire

// File: src/ctss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "call_trace_symbol_stack_top_macros.svh"

module ctss_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire ctss_pkg::op_t     in_op,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire ctss_pkg::status_t status,
    input wire logic              func_known,
    input wire ctss_pkg::depth_t  nest_depth,
    input wire ctss_pkg::addr_t   target_echo
);

    `CTSS_ASSERT_NXT(a_busy_after_item, clk, rst_n, in_valid && in_ready && (in_op == ctss_pkg::OP_LOAD || in_op == ctss_pkg::OP_CALL || in_op == ctss_pkg::OP_RET), !in_ready)
    `CTSS_ASSERT_IMP(a_empty_fields, clk, rst_n, out_valid && status == ctss_pkg::STS_EMPTY, !func_known && nest_depth == '0)
    `CTSS_ASSERT_IMP(a_target_zero, clk, rst_n, out_valid && (status == ctss_pkg::STS_LOADED || status == ctss_pkg::STS_POPPED || status == ctss_pkg::STS_EMPTY), target_echo == '0)
    `CTSS_ASSERT_IMP(a_full_depth, clk, rst_n, out_valid && status == ctss_pkg::STS_FULL, int'(nest_depth) == ctss_pkg::STACK_DEPTH)
    `CTSS_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))

endmodule

bind call_trace_symbol_stack_top ctss_checker u_ctss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .in_op       (item.op),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .status      (result.status),
    .func_known  (result.func_known),
    .nest_depth  (result.nest_depth),
    .target_echo (result.target_echo)
);

`default_nettype wire

// File: verif/call_trace_symbol_stack_top_tb.sv
`timescale 1ns / 1ps

module call_trace_symbol_stack_top_tb;

    localparam ctss_pkg::op_t OP_UNUSED = 2'd3;
    localparam int  SETTLE      = 16;
    localparam int  HOLDOFF_LEN = 300;
    localparam int  STALL_LIMIT = 20000;

    typedef struct packed {
        ctss_pkg::op_t   op;
        ctss_pkg::slot_t slot;
        ctss_pkg::addr_t start;
        ctss_pkg::addr_t target;
        ctss_pkg::addr_t pc;
    } trace_event_t;

    typedef struct packed {
        ctss_pkg::status_t status;
        logic              known;
        ctss_pkg::index_t  index;
        ctss_pkg::depth_t  depth;
        ctss_pkg::addr_t   pc;
        ctss_pkg::addr_t   target;
    } trace_report_t;

    typedef struct {
        bit             cfg_write;
        ctss_pkg::cfg_t cfg_value;
        trace_event_t   ev;
        bit             typed;
        trace_report_t  want;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_wr_en;
    ctss_pkg::cfg_t cfg_wr_data;

    ctss_in_if  trace_in ();
    ctss_out_if trace_out ();

    call_trace_symbol_stack_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (trace_in),
        .result      (trace_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ctss_pkg::addr_t  start_mirror [ctss_pkg::TABLE_DEPTH];
    bit               slot_written [ctss_pkg::TABLE_DEPTH];
    ctss_pkg::frame_t frame_mirror [ctss_pkg::STACK_DEPTH];
    int               depth_mirror;
    int               fn_count_mirror;
    trace_report_t    pending_results [$];
    stim_row_t        directed_rows [$];
    int               error_count;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               holdoff_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit predict_trace_result(input trace_event_t ev,
                                                output trace_report_t r);
        int               n;
        ctss_pkg::frame_t f;
        r = '0;
        f = '0;
        r.pc = ev.pc;
        case (ev.op)
            ctss_pkg::OP_LOAD:
            begin
                start_mirror[ev.slot] = ev.start;
                slot_written[ev.slot] = 1'b1;
                r.status = ctss_pkg::STS_LOADED;
                r.depth = ctss_pkg::depth_t'(depth_mirror);
            end
            ctss_pkg::OP_CALL:
            begin
                n = (fn_count_mirror > ctss_pkg::TABLE_DEPTH)
                  ? ctss_pkg::TABLE_DEPTH : fn_count_mirror;
                f.known = (n != 0);
                f.index = ctss_pkg::index_t'(n - 1);
                for (int i = 0; i < n; i++)
                begin
                    if (start_mirror[i] > ev.target)
                    begin
                        f.known = (i != 0);
                        f.index = (i != 0) ? ctss_pkg::index_t'(i - 1) : '0;
                        break;
                    end
                end
                if (!f.known)
                    f.index = '0;
                r.known = f.known;
                r.index = f.index;
                r.depth = ctss_pkg::depth_t'(depth_mirror);
                r.target = ev.target;
                if (depth_mirror < ctss_pkg::STACK_DEPTH)
                begin
                    frame_mirror[depth_mirror] = f;
                    depth_mirror++;
                    r.status = ctss_pkg::STS_PUSHED;
                end
                else
                    r.status = ctss_pkg::STS_FULL;
            end
            ctss_pkg::OP_RET:
            begin
                if (depth_mirror == 0)
                    r.status = ctss_pkg::STS_EMPTY;
                else
                begin
                    depth_mirror--;
                    f = frame_mirror[depth_mirror];
                    r.status = ctss_pkg::STS_POPPED;
                    r.known = f.known;
                    r.index = f.index;
                    r.depth = ctss_pkg::depth_t'(depth_mirror);
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < ctss_pkg::TABLE_DEPTH && slot_written[n])
            n++;
        return n;
    endfunction

    function automatic trace_event_t make_event(ctss_pkg::op_t op);
        trace_event_t ev;
        ev.op = op;
        ev.slot = ctss_pkg::slot_t'($urandom_range(0, ctss_pkg::TABLE_DEPTH - 1));
        ev.start = $urandom;
        ev.target = $urandom;
        ev.pc = $urandom;
        return ev;
    endfunction

    function automatic ctss_pkg::addr_t pick_call_target();
        int n;
        int r;
        int idx;
        n = (fn_count_mirror > ctss_pkg::TABLE_DEPTH) ? ctss_pkg::TABLE_DEPTH : fn_count_mirror;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (n == 0 || r < 35)
            return $urandom;
        idx = $urandom_range(0, n - 1);
        return start_mirror[idx] + ctss_pkg::addr_t'($urandom_range(0, 4))
             - ctss_pkg::addr_t'(2);
    endfunction

    function automatic void add_item(ctss_pkg::op_t op, ctss_pkg::slot_t slot,
                                     ctss_pkg::addr_t start, ctss_pkg::addr_t target,
                                     ctss_pkg::addr_t pc);
        stim_row_t row;
        row.cfg_write = 1'b0;
        row.cfg_value = '0;
        row.ev.op = op;
        row.ev.slot = slot;
        row.ev.start = start;
        row.ev.target = target;
        row.ev.pc = pc;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(ctss_pkg::op_t op, ctss_pkg::slot_t slot,
                                        ctss_pkg::addr_t start, ctss_pkg::addr_t target,
                                        ctss_pkg::addr_t pc, ctss_pkg::status_t status,
                                        logic known, ctss_pkg::index_t index,
                                        ctss_pkg::depth_t depth);
        add_item(op, slot, start, target, pc);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].want.status = status;
        directed_rows[$].want.known = known;
        directed_rows[$].want.index = index;
        directed_rows[$].want.depth = depth;
        directed_rows[$].want.pc = pc;
        directed_rows[$].want.target = (op == ctss_pkg::OP_CALL) ? target : '0;
    endfunction

    function automatic void add_cfg(ctss_pkg::cfg_t value);
        add_item(OP_UNUSED, '0, '0, '0, '0);
        directed_rows[$].cfg_write = 1'b1;
        directed_rows[$].cfg_value = value;
    endfunction

    task automatic flag_error(string msg);
        $display("[%0t] ERROR %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s mismatch: got %h expected %h", name, got, want));
    endtask

    task automatic send_event(input trace_event_t ev, input bit typed,
                              input trace_report_t want);
        trace_report_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            trace_in.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        trace_in.valid <= 1'b1;
        trace_in.op <= ev.op;
        trace_in.entry_slot <= ev.slot;
        trace_in.entry_start <= ev.start;
        trace_in.call_target <= ev.target;
        trace_in.trace_pc <= ev.pc;
        @(posedge clk);
        while (!trace_in.ready)
            @(posedge clk);
        if (predict_trace_result(ev, predicted))
            pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        trace_in.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_function_count(ctss_pkg::cfg_t value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        fn_count_mirror = value;
    endtask

    task automatic run_trace_phase(int s_pct, int r_pct, int events, bit hold_off,
                                   bit pause);
        int              k;
        int              r;
        bit              sorted;
        ctss_pkg::addr_t a;
        trace_event_t    ev;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        k = $urandom_range(1, 20);
        sorted = ($urandom_range(0, 9) != 0);
        a = $urandom >> 2;
        for (int i = 0; i < k; i++)
        begin
            ev = make_event(ctss_pkg::OP_LOAD);
            ev.slot = ctss_pkg::slot_t'(i);
            if (sorted)
            begin
                ev.start = a;
                a = a + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4096));
            end
            send_event(ev, 1'b0, '0);
        end
        r = $urandom_range(0, 99);
        if (r < 75)
            write_function_count(ctss_pkg::cfg_t'(k));
        else if (r < 90)
            write_function_count(ctss_pkg::cfg_t'($urandom_range(0, written_prefix())));
        else
            write_function_count('0);
        for (int done = 0; done < events; done++)
        begin
            if (hold_off && done == events / 3)
                holdoff_cycles = HOLDOFF_LEN;
            if (pause && done == events / 2)
                drain_results();
            if ($urandom_range(0, 99) < 7)
                send_event(make_event(OP_UNUSED), 1'b0, '0);
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                ev = make_event(ctss_pkg::OP_CALL);
                ev.target = pick_call_target();
            end
            else if (r < 92)
                ev = make_event(ctss_pkg::OP_RET);
            else
            begin
                ev = make_event(ctss_pkg::OP_LOAD);
                if ($urandom_range(0, 1) == 0)
                    ev.slot = ctss_pkg::slot_t'($urandom_range(0, written_prefix() + 1));
            end
            send_event(ev, 1'b0, '0);
        end
    endtask

    initial
    begin
        int           hold_left;
        hold_left = 0;
        trace_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles != 0)
            begin
                hold_left = holdoff_cycles;
                holdoff_cycles = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                trace_out.ready <= 1'b0;
            end
            else
                trace_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        trace_report_t want;
        if (rst_n && trace_out.valid && trace_out.ready)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("result with nothing expected: status %0d pc %h",
                                     trace_out.status, trace_out.pc_echo));
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 32'(trace_out.status), 32'(want.status));
                compare_field("func_known", 32'(trace_out.func_known), 32'(want.known));
                compare_field("func_index", 32'(trace_out.func_index), 32'(want.index));
                compare_field("nest_depth", 32'(trace_out.nest_depth), 32'(want.depth));
                compare_field("pc_echo", trace_out.pc_echo, want.pc);
                compare_field("target_echo", trace_out.target_echo, want.target);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((trace_in.valid && trace_in.ready) || (trace_out.valid && trace_out.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        error_count = 0;
        depth_mirror = 0;
        fn_count_mirror = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        trace_in.valid <= 1'b0;
        trace_in.op <= ctss_pkg::OP_LOAD;
        trace_in.entry_slot <= '0;
        trace_in.entry_start <= '0;
        trace_in.call_target <= '0;
        trace_in.trace_pc <= '0;

        add_checked(ctss_pkg::OP_RET, '0, '0, '0, 32'h0000_0000,
                    ctss_pkg::STS_EMPTY, 1'b0, '0, '0);
        add_checked(ctss_pkg::OP_RET, '1, '1, '1, 32'hFFFF_FFFF,
                    ctss_pkg::STS_EMPTY, 1'b0, '0, '0);
        add_checked(ctss_pkg::OP_CALL, '0, '0, 32'h0000_0000, 32'h0000_1234,
                    ctss_pkg::STS_PUSHED, 1'b0, '0, 11'd0);
        add_checked(ctss_pkg::OP_CALL, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    ctss_pkg::STS_PUSHED, 1'b0, '0, 11'd1);
        add_item(OP_UNUSED, '1, '1, '1, 32'h0000_0030);
        add_checked(ctss_pkg::OP_RET, '0, '0, '0, 32'h0000_0040,
                    ctss_pkg::STS_POPPED, 1'b0, '0, 11'd1);
        add_checked(ctss_pkg::OP_RET, '0, '0, '0, 32'h0000_0044,
                    ctss_pkg::STS_POPPED, 1'b0, '0, 11'd0);
        add_checked(ctss_pkg::OP_LOAD, 10'd0, 32'h0000_0100, 32'hDEAD_BEEF, 32'h0000_0048,
                    ctss_pkg::STS_LOADED, 1'b0, '0, 11'd0);
        add_checked(ctss_pkg::OP_LOAD, 10'd1023, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_004C,
                    ctss_pkg::STS_LOADED, 1'b0, '0, 11'd0);
        add_checked(ctss_pkg::OP_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0050,
                    ctss_pkg::STS_LOADED, 1'b0, '0, 11'd0);
        add_item(ctss_pkg::OP_LOAD, 10'd1, 32'h0000_0200, '0, 32'h0000_0054);
        add_item(ctss_pkg::OP_LOAD, 10'd2, 32'h0000_0200, '0, 32'h0000_0058);
        add_item(ctss_pkg::OP_LOAD, 10'd3, 32'h8000_0000, '0, 32'h0000_005C);
        add_cfg(11'd4);
        add_checked(ctss_pkg::OP_CALL, '0, '0, 32'h0000_00FF, 32'h0000_0060,
                    ctss_pkg::STS_PUSHED, 1'b0, '0, 11'd0);
        add_item(ctss_pkg::OP_CALL, '0, '0, 32'h0000_0100, 32'h0000_0064);
        add_item(ctss_pkg::OP_CALL, '0, '0, 32'h0000_01FF, 32'h0000_0068);
        add_item(ctss_pkg::OP_CALL, '0, '0, 32'h0000_0200, 32'h0000_006C);
        add_item(ctss_pkg::OP_CALL, '0, '0, 32'hFFFF_FFFF, 32'h0000_0070);
        repeat (6) add_item(ctss_pkg::OP_RET, '0, '0, '0, 32'h0000_0074);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg_write)
                write_function_count(directed_rows[i].cfg_value);
            else
                send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
        end

        run_trace_phase(0, 0, 200, 1'b1, 1'b0);
        run_trace_phase(51, 0, 200, 1'b0, 1'b1);
        run_trace_phase(0, 51, 200, 1'b0, 1'b0);
        run_trace_phase(31, 31, 200, 1'b0, 1'b0);

        drain_results();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/ctss_pkg.sv
src/ctss_in_if.sv
src/ctss_out_if.sv
src/ctss_ctrl.sv
src/ctss_dp.sv
src/call_trace_symbol_stack_top.sv
src/ctss_checker.sv
verif/call_trace_symbol_stack_top_tb.sv
